@@ rtl/core/amp_pkg.sv @@
// ----------------------------------------------------------------------------
// amp_pkg: shared types, constants and float helpers for adaptive max pooling
// Format codes, register map and the numeric compare used by the window max.
// ----------------------------------------------------------------------------
`default_nettype none

package amp_pkg;

	localparam int LENGTH_BITS_DEF = 16;
	localparam int DATA_W          = 64;
	localparam int INDEX_W         = 16;
	localparam int ADDR_W          = 4;
	localparam int PDATA_W         = 32;

	typedef enum logic [1:0] {
		FMT_F32  = 2'd0,
		FMT_F16  = 2'd1,
		FMT_BF16 = 2'd2,
		FMT_F64  = 2'd3
	} fmt_t;

	typedef enum logic [1:0] {
		REG_INPUT_LENGTH  = 2'd0,
		REG_OUTPUT_LENGTH = 2'd1,
		REG_DATA_FORMAT   = 2'd2,
		REG_NONE          = 2'd3
	} reg_idx_t;

	// keep only the bits of the selected format
	function automatic logic [DATA_W-1:0] fmt_mask(logic [DATA_W-1:0] v, fmt_t f);
		case (f)
			FMT_F32:           return {32'b0, v[31:0]};
			FMT_F16, FMT_BF16: return {48'b0, v[15:0]};
			default:           return v;
		endcase
	endfunction

	function automatic logic [DATA_W-2:0] fmt_mag(logic [DATA_W-1:0] v, fmt_t f);
		case (f)
			FMT_F32:           return {32'b0, v[30:0]};
			FMT_F16, FMT_BF16: return {48'b0, v[14:0]};
			default:           return v[62:0];
		endcase
	endfunction

	function automatic logic fmt_sign(logic [DATA_W-1:0] v, fmt_t f);
		case (f)
			FMT_F32:           return v[31];
			FMT_F16, FMT_BF16: return v[15];
			default:           return v[63];
		endcase
	endfunction

	function automatic logic [DATA_W-2:0] fmt_inf(fmt_t f);
		case (f)
			FMT_F32:  return 63'h7F80_0000;
			FMT_F16:  return 63'h7C00;
			FMT_BF16: return 63'h7F80;
			default:  return 63'h7FF0_0000_0000_0000;
		endcase
	endfunction

	function automatic logic is_nan(logic [DATA_W-1:0] v, fmt_t f);
		return fmt_mag(v, f) > fmt_inf(f);
	endfunction

	// a > b as numbers, neither a NaN; the two zeros compare equal
	function automatic logic fp_greater(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
		fmt_t f);
		logic [DATA_W-2:0] ma;
		logic [DATA_W-2:0] mb;
		logic              na;
		logic              nb;
		ma = fmt_mag(a, f);
		mb = fmt_mag(b, f);
		na = fmt_sign(a, f);
		nb = fmt_sign(b, f);
		if (ma == '0 && mb == '0) return 1'b0;
		if (na != nb) return nb;
		return na ? (ma < mb) : (ma > mb);
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/adaptive_max_pool_1d.sv @@
// ----------------------------------------------------------------------------
// adaptive_max_pool_1d: streaming adaptive 1-D max pooling
// Rows of L samples in, one window maximum out per window end.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall, sample_bits): one sample per transfer,
//    rows back to back. Output channel (out_valid/out_stall) carries
//    pooled_bits, window_index, row_done and config_error.
//  - Throughput: one sample per cycle while in_stall is low. A sample is
//    registered, then folded into the running maxima as it moves to the
//    result register that drives out_valid.
//  - Configuration over APB: 0x0 row length L, 0x4 window count O,
//    0x8 data_format. Each write starts a divider run, from a register set
//    by the write, that yields L/O and L%O; in_stall is high from the access
//    cycle until the run ends, and the row then restarts at sample 0.
//  - Reset: L = O = 1, f32, row at its start; no divider run is needed.
//  - When the receiver stalls the result register holds, the input register
//    fills, and in_stall rises until the result is taken.
//  - Invalid lengths (O > L or zero): one result per row with config_error.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_max_pool_1d import amp_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// APB config
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready,
	// sample input
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [DATA_W-1:0]  sample_bits,
	// result output
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [DATA_W-1:0]       pooled_bits,
	output logic [INDEX_W-1:0]      window_index,
	output logic                    row_done,
	output logic                    config_error
);

	localparam int W = LENGTH_BITS;

	// config registers
	logic [W-1:0] in_len_q;
	logic [W-1:0] out_len_q;
	fmt_t         fmt_q;

	// divider results: step quotient and remainder
	logic         div_start_q;
	logic         div_busy;
	logic         div_done;
	logic [W-1:0] sq;
	logic [W-1:0] sr;

	// row state
	logic [W-1:0]      pos_q;
	logic [W-1:0]      wcnt_q;
	logic [DATA_W-1:0] cur_max_q;
	logic              cur_vld_q;
	logic [DATA_W-1:0] nxt_max_q;
	logic              nxt_vld_q;
	logic [W-1:0]      wend_q;
	logic [W-1:0]      erem_q;
	logic [W-1:0]      nstart_q;
	logic [W-1:0]      srem_q;

	// input register
	logic              vld_s1;
	logic [DATA_W-1:0] smp_s1;

	// result register
	logic              vld_s2;
	logic [DATA_W-1:0] pooled_s2;
	logic [W-1:0]      widx_s2;
	logic              rdone_s2;
	logic              cerr_s2;

	logic cfg_wr;
	logic adv;
	logic bad;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (reg_idx_t'(paddr[3:2]) != REG_NONE);

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_INPUT_LENGTH:  prdata = PDATA_W'(in_len_q);
			REG_OUTPUT_LENGTH: prdata = PDATA_W'(out_len_q);
			REG_DATA_FORMAT:   prdata = PDATA_W'(fmt_q);
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_len_q  <= W'(1);
			out_len_q <= W'(1);
			fmt_q     <= FMT_F32;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_INPUT_LENGTH:  in_len_q  <= pwdata[W-1:0];
				REG_OUTPUT_LENGTH: out_len_q <= pwdata[W-1:0];
				REG_DATA_FORMAT:   fmt_q     <= fmt_t'(pwdata[1:0]);
				default:           ;
			endcase
		end
	end

	// divider starts once the written value sits in its register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= cfg_wr;
		end
	end

	amp_div #(.LENGTH_BITS(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (in_len_q),
		.divisor  (out_len_q),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (sq),
		.rem      (sr)
	);

	assign bad = (out_len_q == '0) || (in_len_q == '0) || (out_len_q > in_len_q);

	// handshakes: s1 moves on when the result register is free or drains
	assign adv      = !vld_s2 || !out_stall;
	assign in_stall = div_busy || cfg_wr || div_start_q || (vld_s1 && !adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			smp_s1 <= fmt_mask(sample_bits, fmt_q);
		end
	end

	// running maxima
	logic [DATA_W-1:0] cur_fold;
	logic [DATA_W-1:0] nxt_fold;

	amp_fold u_fold_cur (
		.acc       (cur_max_q),
		.acc_valid (cur_vld_q),
		.sample    (smp_s1),
		.fmt       (fmt_q),
		.acc_next  (cur_fold)
	);

	amp_fold u_fold_nxt (
		.acc       (nxt_max_q),
		.acc_valid (nxt_vld_q),
		.sample    (smp_s1),
		.fmt       (fmt_q),
		.acc_next  (nxt_fold)
	);

	// row-start bounds: ceil and floor of L/O with their remainders
	logic [W-1:0] rs_wend;
	logic [W-1:0] rs_erem;
	logic [W-1:0] rs_nstart;
	logic [W-1:0] rs_srem;

	always_comb begin
		if (bad) begin
			rs_wend   = '0;
			rs_erem   = '0;
			rs_nstart = '0;
			rs_srem   = '0;
		end else begin
			rs_wend   = sq + W'(sr != '0);
			rs_erem   = (sr == '0) ? (out_len_q - W'(1)) : (sr - W'(1));
			rs_nstart = sq;
			rs_srem   = sr;
		end
	end

	// per-sample decisions
	logic [W:0]   pos_inc;
	logic [W:0]   wcnt_inc;
	logic [W:0]   rowlen;
	logic         take_nxt;
	logic         win_end;
	logic         last_win;
	logic         row_end;
	logic [W:0]   esum;
	logic [W:0]   ssum;
	logic         ecy;
	logic         scy;

	assign pos_inc  = {1'b0, pos_q} + (W+1)'(1);
	assign wcnt_inc = {1'b0, wcnt_q} + (W+1)'(1);
	assign rowlen   = (in_len_q == '0) ? (W+1)'(1) : {1'b0, in_len_q};
	assign take_nxt = (wcnt_inc < {1'b0, out_len_q}) && (pos_q >= nstart_q);
	assign win_end  = pos_inc >= {1'b0, wend_q};
	assign last_win = wcnt_inc >= {1'b0, out_len_q};
	assign row_end  = pos_inc >= rowlen;
	assign esum     = {1'b0, erem_q} + {1'b0, sr};
	assign ssum     = {1'b0, srem_q} + {1'b0, sr};
	assign ecy      = esum >= {1'b0, out_len_q};
	assign scy      = ssum >= {1'b0, out_len_q};

	logic fire;
	assign fire = vld_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			wcnt_q    <= '0;
			cur_max_q <= '0;
			cur_vld_q <= 1'b0;
			nxt_max_q <= '0;
			nxt_vld_q <= 1'b0;
			wend_q    <= W'(1);
			erem_q    <= '0;
			nstart_q  <= W'(1);
			srem_q    <= '0;
		end else if (div_done || (fire && (row_end || (!bad && win_end && last_win)))) begin
			pos_q     <= '0;
			wcnt_q    <= '0;
			cur_max_q <= '0;
			cur_vld_q <= 1'b0;
			nxt_max_q <= '0;
			nxt_vld_q <= 1'b0;
			wend_q    <= rs_wend;
			erem_q    <= rs_erem;
			nstart_q  <= rs_nstart;
			srem_q    <= rs_srem;
		end else if (fire) begin
			pos_q <= pos_inc[W-1:0];
			if (!bad) begin
				if (win_end) begin
					// hand the next window's maximum over and step both bounds
					cur_max_q <= take_nxt ? nxt_fold : nxt_max_q;
					cur_vld_q <= take_nxt || nxt_vld_q;
					nxt_max_q <= '0;
					nxt_vld_q <= 1'b0;
					wcnt_q    <= wcnt_inc[W-1:0];
					wend_q    <= wend_q + sq + W'(ecy);
					erem_q    <= ecy ? W'(esum - {1'b0, out_len_q}) : esum[W-1:0];
					nstart_q  <= nstart_q + sq + W'(scy);
					srem_q    <= scy ? W'(ssum - {1'b0, out_len_q}) : ssum[W-1:0];
				end else begin
					cur_max_q <= cur_fold;
					cur_vld_q <= 1'b1;
					if (take_nxt) begin
						nxt_max_q <= nxt_fold;
						nxt_vld_q <= 1'b1;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1 && (bad ? row_end : win_end);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (bad) begin
				pooled_s2 <= '0;
				widx_s2   <= '0;
				rdone_s2  <= 1'b1;
				cerr_s2   <= 1'b1;
			end else begin
				pooled_s2 <= cur_fold;
				widx_s2   <= wcnt_q;
				rdone_s2  <= last_win;
				cerr_s2   <= 1'b0;
			end
		end
	end

	assign out_valid    = vld_s2;
	assign pooled_bits  = pooled_s2;
	assign window_index = INDEX_W'(widx_s2);
	assign row_done     = rdone_s2;
	assign config_error = cerr_s2;

endmodule

`default_nettype wire

@@ rtl/core/amp_div.sv @@
// ----------------------------------------------------------------------------
// amp_div: restoring divider for the window step
// One quotient bit per cycle while busy; yields L/O and L%O and pulses done.
// ----------------------------------------------------------------------------
`default_nettype none

module amp_div import amp_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [LENGTH_BITS-1:0] dividend,
	input  wire logic [LENGTH_BITS-1:0] divisor,
	output logic                        busy,
	output logic                        done,
	output logic [LENGTH_BITS-1:0]      quot,
	output logic [LENGTH_BITS-1:0]      rem
);

	localparam int CW = $clog2(LENGTH_BITS + 1);

	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [LENGTH_BITS:0]   rem_q;
	logic [LENGTH_BITS-1:0] quot_q;
	logic [LENGTH_BITS:0]   rem_sh;
	logic                   ge;

	assign rem_sh = {rem_q[LENGTH_BITS-1:0], quot_q[LENGTH_BITS-1]};
	assign ge     = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rem_q  <= '0;
			quot_q <= LENGTH_BITS'(1);
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(LENGTH_BITS);
				rem_q  <= '0;
				quot_q <= dividend;
			end else if (busy_q) begin
				rem_q  <= ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
				quot_q <= {quot_q[LENGTH_BITS-2:0], ge};
				cnt_q  <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q[LENGTH_BITS-1:0];

endmodule

`default_nettype wire

@@ rtl/core/amp_fold.sv @@
// ----------------------------------------------------------------------------
// amp_fold: one step of a running maximum
// First sample loads; a held NaN sticks; a NaN or larger sample replaces.
// ----------------------------------------------------------------------------
`default_nettype none

module amp_fold import amp_pkg::*; (
	input  wire logic [DATA_W-1:0] acc,
	input  wire logic              acc_valid,
	input  wire logic [DATA_W-1:0] sample,
	input  wire fmt_t              fmt,
	output logic [DATA_W-1:0]      acc_next
);

	always_comb begin
		acc_next = acc;
		if (!acc_valid) begin
			acc_next = sample;
		end else if (!is_nan(acc, fmt)) begin
			if (is_nan(sample, fmt) || fp_greater(sample, acc, fmt)) begin
				acc_next = sample;
			end
		end
	end

endmodule

`default_nettype wire

@@ test/adaptive_max_pool_1d_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adaptive_max_pool_1d_tb: self-checking bench for streaming adaptive max pool
// Drives sample rows under several length/format settings (extremes, invalid
// lengths, NaN/zero/infinity samples), predicts each window maximum and checks
// every result transfer in order, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_max_pool_1d_tb;
	import amp_pkg::*;

	localparam int LEN_W      = 16;
	localparam int CYCLE_CAP  = 1500000;
	localparam int ITEM_GOAL  = 1950;

	typedef struct {
		logic [63:0] pooled;
		logic [15:0] index;
		logic        done;
		logic        err;
	} window_result_t;

	// bit width of one sample in the given format
	function automatic int sample_width(fmt_t f);
		case (f)
			FMT_F32:           return 32;
			FMT_F16, FMT_BF16: return 16;
			default:           return 64;
		endcase
	endfunction

	function automatic logic [63:0] inf_bits(fmt_t f);
		case (f)
			FMT_F32:  return 64'h7F80_0000;
			FMT_F16:  return 64'h7C00;
			FMT_BF16: return 64'h7F80;
			default:  return 64'h7FF0_0000_0000_0000;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Window-max predictor and expected-result queue.
	// ------------------------------------------------------------------------
	class pool_scoreboard;
		int unsigned    row_len, win_count_cfg;
		fmt_t           fmt;
		int unsigned    pos, win, win_end, nxt_start, end_rem, start_rem;
		logic [63:0]    cur_max, nxt_max;
		bit             cur_ok, nxt_ok;
		window_result_t pending[$];
		int             fails;

		function void init();
			row_len = 1;
			win_count_cfg = 1;
			fmt = FMT_F32;
			fails = 0;
			restart_row();
		endfunction

		function bit lengths_bad();
			return win_count_cfg == 0 || row_len == 0 || win_count_cfg > row_len;
		endfunction

		function void restart_row();
			pos = 0;
			win = 0;
			cur_max = '0;
			nxt_max = '0;
			cur_ok = 0;
			nxt_ok = 0;
			if (lengths_bad()) begin
				win_end = 0; end_rem = 0; nxt_start = 0; start_rem = 0;
			end else begin
				win_end   = (row_len + win_count_cfg - 1) / win_count_cfg;
				end_rem   = (row_len + win_count_cfg - 1) % win_count_cfg;
				nxt_start = row_len / win_count_cfg;
				start_rem = row_len % win_count_cfg;
			end
		endfunction

		function bit nan_bits(logic [63:0] v);
			logic [63:0] sb;
			sb = 64'd1 << (sample_width(fmt) - 1);
			return (v & (sb - 1)) > inf_bits(fmt);
		endfunction

		// numeric a > b, neither a NaN; both zeros equal
		function bit above(logic [63:0] a, logic [63:0] b);
			logic [63:0] sb, ma, mb;
			bit          na, nb;
			sb = 64'd1 << (sample_width(fmt) - 1);
			ma = a & (sb - 1);
			mb = b & (sb - 1);
			na = (a & sb) != 0;
			nb = (b & sb) != 0;
			if (ma == 0 && mb == 0) return 0;
			if (na != nb) return nb;
			return na ? (ma < mb) : (ma > mb);
		endfunction

		// first NaN sticks; ties keep the earlier sample
		function void fold(ref logic [63:0] acc, ref bit ok, input logic [63:0] s);
			if (!ok) begin
				acc = s;
				ok = 1;
			end else if (!nan_bits(acc) && (nan_bits(s) || above(s, acc))) begin
				acc = s;
			end
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] val);
			case (idx)
				REG_INPUT_LENGTH:  row_len = val[LEN_W-1:0];
				REG_OUTPUT_LENGTH: win_count_cfg = val[LEN_W-1:0];
				REG_DATA_FORMAT:   fmt = fmt_t'(val[1:0]);
				default:           return;
			endcase
			restart_row();
		endfunction

		// accepted input transfer: queue the result it causes, if any
		function void note_sample(logic [63:0] raw);
			logic [63:0]    s;
			window_result_t r;
			int unsigned    w, len1;
			bit             last;
			w = sample_width(fmt);
			s = (w == 64) ? raw : (raw & ((64'd1 << w) - 1));
			if (lengths_bad()) begin
				len1 = row_len ? row_len : 1;
				if (pos + 1 >= len1) begin
					pos = 0;
					r.pooled = '0; r.index = '0; r.done = 1; r.err = 1;
					pending.push_back(r);
				end else begin
					pos = (pos + 1) & 16'hFFFF;
				end
				return;
			end
			fold(cur_max, cur_ok, s);
			if (win + 1 < win_count_cfg && pos >= nxt_start) fold(nxt_max, nxt_ok, s);
			if (pos + 1 >= win_end) begin
				last = (win + 1 >= win_count_cfg);
				r.pooled = cur_max; r.index = win[15:0]; r.done = last; r.err = 0;
				pending.push_back(r);
				if (last) begin
					restart_row();
					return;
				end
				cur_max = nxt_max;
				cur_ok  = nxt_ok;
				nxt_max = '0;
				nxt_ok  = 0;
				win = (win + 1) & 16'hFFFF;
				win_end += row_len / win_count_cfg;
				end_rem += row_len % win_count_cfg;
				if (end_rem >= win_count_cfg) begin
					win_end++;
					end_rem -= win_count_cfg;
				end
				nxt_start += row_len / win_count_cfg;
				start_rem += row_len % win_count_cfg;
				if (start_rem >= win_count_cfg) begin
					nxt_start++;
					start_rem -= win_count_cfg;
				end
			end
			if (pos + 1 >= row_len) restart_row();
			else pos = (pos + 1) & 16'hFFFF;
		endfunction

		function void match_output(window_result_t got);
			window_result_t want;
			if (pending.size() == 0) begin
				$error("unexpected result transfer: pooled_bits=%h", got.pooled);
				fails++;
				return;
			end
			want = pending.pop_front();
			if (got.pooled !== want.pooled) begin
				$error("pooled_bits: expected %h, got %h", want.pooled, got.pooled);
				fails++;
			end
			if (got.index !== want.index) begin
				$error("window_index: expected %0d, got %0d", want.index, got.index);
				fails++;
			end
			if (got.done !== want.done) begin
				$error("row_done: expected %0b, got %0b", want.done, got.done);
				fails++;
			end
			if (got.err !== want.err) begin
				$error("config_error: expected %0b, got %0b", want.err, got.err);
				fails++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------------
	logic               clk = 0;
	logic               arst_n = 0;
	logic               psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid = 0;
	logic               in_stall;
	logic [DATA_W-1:0]  sample_bits = '0;
	logic               out_valid;
	logic               out_stall = 0;
	logic [DATA_W-1:0]  pooled_bits;
	logic [INDEX_W-1:0] window_index;
	logic               row_done;
	logic               config_error;

	adaptive_max_pool_1d uut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	pool_scoreboard sb = new();
	fmt_t           cur_fmt = FMT_F32;
	bit             quiet = 0;      // no gaps or stalls in this phase
	int             sent = 0;
	int unsigned    cycles = 0;
	int             stall_left = 0;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side: check each transfer, then choose next stall
	always @(posedge clk) begin
		window_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.pooled = pooled_bits;
			got.index = window_index;
			got.done = row_done;
			got.err = config_error;
			sb.match_output(got);
		end
		if (quiet) begin
			out_stall <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60)
				: $urandom_range(0, 2);
			out_stall <= 1;
		end else begin
			out_stall <= 0;
		end
	end

	// sample patterns: 0 +0, 1 -0, 2 +inf, 3 -inf, 4 NaN, 5 all-ones NaN,
	// 6 coarse values that tie often, other: fully random
	function automatic logic [63:0] make_sample(fmt_t f, int kind);
		int          w;
		logic [63:0] sgn, v, rnd;
		w   = sample_width(f);
		sgn = 64'd1 << (w - 1);
		rnd = {$urandom, $urandom};
		case (kind)
			0:       v = 0;
			1:       v = sgn;
			2:       v = inf_bits(f);
			3:       v = inf_bits(f) | sgn;
			4:       v = inf_bits(f) | $urandom_range(1, 3) | (rnd[0] ? sgn : 0);
			5:       v = (sgn - 1) | (rnd[1] ? sgn : 0);
			6:       v = (64'($urandom_range(0, 3)) << (w - 4)) | (rnd[2] ? sgn : 0);
			default: v = rnd;
		endcase
		if (w < 64) v = (v & ((64'd1 << w) - 1)) | (rnd & ~((64'd1 << w) - 1));
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// one input transfer, valid held across back-to-back items
	task automatic send_sample(logic [63:0] s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		sample_bits <= s;
		do @(posedge clk); while (in_stall);
		sb.note_sample(s);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		// let a sample with no result leave the pipeline
		repeat (8) @(posedge clk);
	endtask

	// APB write: setup, then access until pready, then back to idle
	task automatic apb_write(reg_idx_t idx, logic [31:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.write_reg(idx, val);
		if (idx == REG_DATA_FORMAT) cur_fmt = fmt_t'(val[1:0]);
		@(posedge clk);
	endtask

	task automatic set_lengths(int unsigned len, int unsigned wins, fmt_t f);
		drain();
		apb_write(REG_DATA_FORMAT, 32'(f));
		apb_write(REG_INPUT_LENGTH, len);
		apb_write(REG_OUTPUT_LENGTH, wins);
	endtask

	initial begin
		int unsigned len, wins, rows;
		int          phase;
		sb.init();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset setting: one-sample rows in f32
		send_sample(make_sample(FMT_F32, 4));
		send_sample(make_sample(FMT_F32, 1));
		send_sample(make_sample(FMT_F32, 7));
		// f64, overlapping windows; NaN, zeros, infinities
		set_lengths(4, 3, FMT_F64);
		for (int k = 0; k < 8; k++) send_sample(make_sample(FMT_F64, k));
		// more windows than samples: error result per row
		set_lengths(2, 3, FMT_F16);
		for (int k = 0; k < 4; k++) send_sample(make_sample(FMT_F16, k + 2));
		// largest lengths, one window per sample
		set_lengths(65535, 65535, FMT_BF16);
		for (int k = 0; k < 4; k++) send_sample(make_sample(FMT_BF16, k + 4));
		set_lengths(1, 65535, FMT_BF16);
		send_sample(make_sample(FMT_BF16, 7));
		send_sample(make_sample(FMT_BF16, 0));
		// unmapped address must change nothing
		drain();
		apb_write(REG_NONE, 32'hFFFF_FFFF);
		send_sample(make_sample(FMT_BF16, 7));
		// one huge window; a partial row gives no result
		set_lengths(65535, 1, FMT_F32);
		for (int k = 0; k < 3; k++) send_sample(make_sample(FMT_F32, 7));

		phase = 0;
		while (sent < ITEM_GOAL) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200)
				: $urandom_range(1, 24);
			wins = ($urandom_range(0, 9) == 0) ? len + $urandom_range(1, 5)
				: $urandom_range(1, len);
			set_lengths(len, wins, fmt_t'($urandom_range(0, 3)));
			quiet = ($urandom_range(0, 4) == 0);
			rows = $urandom_range(1, 5);
			for (int n = 0; n < rows * len && sent < ITEM_GOAL; n++) begin
				send_sample(make_sample(cur_fmt, $urandom_range(0, 11)));
				// sender holds off until all results are back
				if (phase == 3 && n == len / 2) begin
					in_valid <= 0;
					do @(posedge clk); while (sb.pending.size() != 0);
				end
			end
			quiet = 0;
			phase++;
		end

		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.fails == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
